// ===== hdl/rational_arithmetic_unit_macros.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Assert that a property holds at every rising edge outside reset.
`define RAU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rau_pkg.sv =====
package rau_pkg;

	// Command codes
	localparam logic [2:0] CMD_ADD   = 3'd0;
	localparam logic [2:0] CMD_SUB   = 3'd1;
	localparam logic [2:0] CMD_MUL   = 3'd2;
	localparam logic [2:0] CMD_DIV   = 3'd3;
	localparam logic [2:0] CMD_CMP   = 3'd4;
	localparam logic [2:0] CMD_FLOOR = 3'd5;
	localparam logic [2:0] CMD_CEIL  = 3'd6;
	localparam logic [2:0] CMD_RED   = 3'd7;

	// Status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZDEN   = 2'd1;
	localparam logic [1:0] ST_DIVZ   = 2'd2;

	localparam int unsigned WIDE = 63;

	// Sequencer states
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_MUL1  = 7'b0000010,
		S_MUL2  = 7'b0000100,
		S_COMB  = 7'b0001000,
		S_GCD   = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

endpackage

// ===== hdl/rational_arithmetic_unit.sv =====
// Rational arithmetic unit.
// Input channel s_axis_*: one transfer carries a command and two signed
// fractions. tdata, lowest bit first: cmd(3) lhs_neg lhs_num(31) lhs_den(31)
// rhs_neg rhs_num(31) rhs_den(31), zero padded to 136 bits.
// Output channel m_axis_*: one transfer per input. tdata, lowest bit first:
// res_neg res_num(63) res_den(63) int_result(32) less_than equal status(2),
// zero padded to 168 bits.
// Work is done by one shared 64-bit add/subtract unit under a sequencer:
// up to three shift-add products of 32 steps each, then a Euclidean gcd with
// restoring remainder steps, then two 64-step divisions by the gcd. Floor
// and ceiling run a single 64-step division of numerator by denominator;
// compare stops after its products. Error items go straight to the output.
// One item at a time: s_axis_tready is high only while idle, the next
// item is taken the cycle after the result is loaded. A finished result
// waits in the sequencer until the output register is free; a stalled
// receiver holds the block. Reset clears the sequencer and the output valid;
// payload registers are not reset.
module rational_arithmetic_unit #(
	parameter int MAG_BITS = 31
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// cmd, lhs_neg, lhs_num, lhs_den, rhs_neg, rhs_num, rhs_den
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// res_neg, res_num, res_den, int_result, less_than, equal, status
	output logic [167:0] m_axis_tdata
);

	localparam int W = rau_pkg::WIDE + 1;

	rau_pkg::state_t state_q;

	logic [2:0]  cmd_q;
	logic        sa_q, sc_q;
	logic [30:0] a_q, b_q, c_q, d_q;

	// Shared operands / working registers
	logic [W-1:0] x_q, y_q, p_q, acc_q, rem_q, quo_q, l_q, r_q, bd_q;
	logic [W-1:0] num_q, den_q, g_q;
	logic [6:0]   cnt_q;
	logic [1:0]   phase_q;   // multiply, combine or divide phase being run
	logic         rneg_q;

	logic         o_neg_q, o_lt_q, o_eq_q;
	logic [62:0]  o_num_q, o_den_q;
	logic [31:0]  o_int_q;
	logic [1:0]   o_st_q;
	logic         ovalid_q;
	logic [167:0] tdata_q;

	// Input unpack, masked to MAG_BITS
	logic [30:0] mag_mask;
	logic [2:0]  in_cmd;
	logic [30:0] in_a, in_b, in_c, in_d;
	assign mag_mask = 31'((64'd1 << MAG_BITS) - 64'd1);
	assign in_cmd = s_axis_tdata[2:0];
	assign in_a = s_axis_tdata[34:4] & mag_mask;
	assign in_b = s_axis_tdata[65:35] & mag_mask;
	assign in_c = s_axis_tdata[97:67] & mag_mask;
	assign in_d = s_axis_tdata[128:98] & mag_mask;

	// The one shared adder/subtractor
	logic [W-1:0] alu_a, alu_b, alu_y;
	logic         alu_sub;
	logic [W:0]   alu_full;
	assign alu_full = alu_sub ? {1'b0, alu_a} - {1'b0, alu_b} : {1'b0, alu_a} + {1'b0, alu_b};
	assign alu_y = alu_full[W-1:0];

	// Remainder step view for gcd and divide phases
	logic [W-1:0] rem_sh;
	assign rem_sh = {rem_q[W-2:0], quo_q[W-1]};

	always_comb begin
		alu_a = acc_q;
		alu_b = x_q;
		alu_sub = 1'b0;
		unique case (state_q)
			rau_pkg::S_COMB: begin
				alu_a = l_q;
				alu_b = r_q;
				alu_sub = phase_q[0];
			end
			rau_pkg::S_GCD, rau_pkg::S_DIV: begin
				alu_a = rem_sh;
				alu_b = y_q;
				alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	logic fin_ok;
	assign fin_ok = !ovalid_q || m_axis_tready;

	// Output register: loaded from the finished result when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == rau_pkg::S_OUT && fin_ok) begin
			ovalid_q <= 1'b1;
			tdata_q <= {5'b00000, o_st_q, o_eq_q, o_lt_q, o_int_q, o_den_q, o_num_q,
				o_neg_q};
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rau_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				rau_pkg::S_IDLE: begin
					if (s_axis_tvalid) begin
						cmd_q <= in_cmd;
						a_q <= in_a; b_q <= in_b; c_q <= in_c; d_q <= in_d;
						sa_q <= s_axis_tdata[3] && (in_a != '0);
						sc_q <= s_axis_tdata[66] && (in_c != '0);
						o_neg_q <= 1'b0; o_num_q <= '0; o_den_q <= 63'd1;
						o_int_q <= '0; o_lt_q <= 1'b0; o_eq_q <= 1'b0;
						o_st_q <= rau_pkg::ST_OK;
						if (in_b == '0 || (in_cmd <= rau_pkg::CMD_CMP && in_d == '0)) begin
							o_st_q <= rau_pkg::ST_ZDEN;
							state_q <= rau_pkg::S_OUT;
						end else if (in_cmd == rau_pkg::CMD_DIV && in_c == '0) begin
							o_st_q <= rau_pkg::ST_DIVZ;
							state_q <= rau_pkg::S_OUT;
						end else if (in_cmd == rau_pkg::CMD_FLOOR ||
								in_cmd == rau_pkg::CMD_CEIL) begin
							// a / b by restoring division
							rem_q <= '0; quo_q <= W'(in_a); y_q <= W'(in_b);
							cnt_q <= 7'(W); phase_q <= 2'd3;
							state_q <= rau_pkg::S_DIV;
						end else if (in_cmd == rau_pkg::CMD_RED) begin
							num_q <= W'(in_a); den_q <= W'(in_b);
							rneg_q <= s_axis_tdata[3] && (in_a != '0);
							x_q <= W'(in_a); y_q <= W'(in_b);
							rem_q <= '0; quo_q <= W'(in_a); cnt_q <= 7'(W);
							state_q <= rau_pkg::S_GCD;
						end else begin
							// first product: numerator-side term
							acc_q <= '0; cnt_q <= 7'd0; phase_q <= 2'd0;
							if (in_cmd == rau_pkg::CMD_MUL) begin
								x_q <= W'(in_a); p_q <= W'(in_c);
							end else begin
								x_q <= W'(in_a); p_q <= W'(in_d);
							end
							state_q <= rau_pkg::S_MUL1;
						end
					end
				end
				// shift-add multiply, one multiplier bit a cycle
				rau_pkg::S_MUL1, rau_pkg::S_MUL2: begin
					if (p_q[0]) acc_q <= alu_y;
					x_q <= {x_q[W-2:0], 1'b0};
					p_q <= {1'b0, p_q[W-1:1]};
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd31) begin
						cnt_q <= 7'd0;
						acc_q <= '0;
						phase_q <= phase_q + 2'd1;
						unique case (phase_q)
							2'd0: begin
								l_q <= p_q[0] ? alu_y : acc_q;
								x_q <= (cmd_q == rau_pkg::CMD_DIV) ? W'(b_q) : W'(c_q);
								p_q <= (cmd_q == rau_pkg::CMD_DIV) ? W'(c_q) : W'(b_q);
							end
							2'd1: begin
								r_q <= p_q[0] ? alu_y : acc_q;
								x_q <= W'(b_q); p_q <= W'(d_q);
								if (cmd_q == rau_pkg::CMD_CMP) begin
									phase_q <= 2'd3;
									state_q <= rau_pkg::S_COMB;
								end else if (cmd_q == rau_pkg::CMD_DIV) begin
									phase_q <= 2'd3;
									state_q <= rau_pkg::S_COMB;
								end
							end
							default: begin
								bd_q <= p_q[0] ? alu_y : acc_q;
								phase_q <= 2'd0;
								state_q <= rau_pkg::S_COMB;
							end
						endcase
					end
				end
				// sign combine / compare (phase 0 picks sign, 1 subtracts l-r, 2 adds)
				rau_pkg::S_COMB: begin
					if (cmd_q == rau_pkg::CMD_CMP) begin
						if (sa_q != sc_q) begin
							o_lt_q <= sa_q;
						end else begin
							o_lt_q <= sa_q ? (l_q > r_q) : (l_q < r_q);
							o_eq_q <= l_q == r_q;
						end
						state_q <= rau_pkg::S_OUT;
					end else if (cmd_q == rau_pkg::CMD_MUL || cmd_q == rau_pkg::CMD_DIV) begin
						num_q <= l_q;
						den_q <= (cmd_q == rau_pkg::CMD_MUL) ? bd_q : r_q;
						rneg_q <= sa_q != sc_q;
						x_q <= l_q;
						y_q <= (cmd_q == rau_pkg::CMD_MUL) ? bd_q : r_q;
						rem_q <= '0; quo_q <= l_q; cnt_q <= 7'(W);
						state_q <= rau_pkg::S_GCD;
					end else if (phase_q == 2'd0) begin
						// decide sign, then pick operation
						logic sr;
						sr = (cmd_q == rau_pkg::CMD_SUB) ? (!sc_q && c_q != '0) : sc_q;
						if (sa_q == sr) begin
							rneg_q <= sa_q;
							phase_q <= 2'd2;
						end else if (l_q >= r_q) begin
							rneg_q <= sa_q;
							phase_q <= 2'd1;
						end else begin
							rneg_q <= sr;
							l_q <= r_q; r_q <= l_q;
							phase_q <= 2'd1;
						end
					end else begin
						// shared unit adds in phase 2, subtracts in phase 1
						logic [W-1:0] m;
						m = alu_y;
						num_q <= m; den_q <= bd_q;
						x_q <= m; y_q <= bd_q;
						rem_q <= '0; quo_q <= m; cnt_q <= 7'(W);
						state_q <= rau_pkg::S_GCD;
					end
				end
				// Euclid: x mod y by restoring steps, then swap
				rau_pkg::S_GCD: begin
					if (num_q == '0) begin
						state_q <= rau_pkg::S_OUT;
					end else if (y_q == '0) begin
						g_q <= x_q;
						rem_q <= '0; quo_q <= num_q; y_q <= x_q;
						cnt_q <= 7'(W); phase_q <= 2'd0;
						state_q <= rau_pkg::S_DIV;
					end else begin
						if (!alu_full[W]) rem_q <= alu_y;
						else rem_q <= rem_sh;
						quo_q <= {quo_q[W-2:0], 1'b0};
						cnt_q <= cnt_q - 7'd1;
						if (cnt_q == 7'd1) begin
							x_q <= y_q;
							y_q <= !alu_full[W] ? alu_y : rem_sh;
							rem_q <= '0;
							quo_q <= y_q;
							cnt_q <= 7'(W);
						end
					end
				end
				// restoring division: phase 0 num/g, 1 den/g, 3 floor/ceil
				rau_pkg::S_DIV: begin
					logic [W-1:0] qn, rn;
					qn = {quo_q[W-2:0], !alu_full[W]};
					rn = !alu_full[W] ? alu_y : rem_sh;
					rem_q <= rn; quo_q <= qn;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == 7'd1) begin
						unique case (phase_q)
							2'd0: begin
								o_num_q <= qn[62:0];
								o_neg_q <= rneg_q;
								rem_q <= '0; quo_q <= den_q; y_q <= g_q;
								cnt_q <= 7'(W); phase_q <= 2'd1;
							end
							2'd1: begin
								o_den_q <= qn[62:0];
								state_q <= rau_pkg::S_OUT;
							end
							default: begin
								logic [31:0] q32;
								q32 = qn[31:0];
								if (sa_q) begin
									o_int_q <= 32'd0 - ((cmd_q == rau_pkg::CMD_FLOOR &&
										rn != '0) ? q32 + 32'd1 : q32);
								end else begin
									o_int_q <= (cmd_q == rau_pkg::CMD_CEIL && rn != '0) ?
										q32 + 32'd1 : q32;
								end
								state_q <= rau_pkg::S_OUT;
							end
						endcase
					end
				end
				// wait for the output register to be free
				rau_pkg::S_OUT: begin
					if (fin_ok)
						state_q <= rau_pkg::S_IDLE;
				end
				default: state_q <= rau_pkg::S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == rau_pkg::S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = tdata_q;

	`include "rational_arithmetic_unit_macros.svh"

	`RAU_ASSERT(a_ready_idle, !(s_axis_tready && state_q != rau_pkg::S_IDLE), "ready outside idle")
	`RAU_ASSERT(a_neg_zero, !(m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[63:1] == '0), "negative zero result")
	`RAU_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed under stall")

endmodule

// ===== bench/rational_arithmetic_unit_tb.sv =====
module rational_arithmetic_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1450;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct packed {
		logic [30:0] rhs_den;
		logic [30:0] rhs_num;
		logic        rhs_neg;
		logic [30:0] lhs_den;
		logic [30:0] lhs_num;
		logic        lhs_neg;
		logic [2:0]  cmd;
	} operands_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        equal;
		logic        less_than;
		logic [31:0] int_result;
		logic [62:0] res_den;
		logic [62:0] res_num;
		logic        res_neg;
	} answer_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [167:0] m_axis_tdata;

	operands_t pending_ops[$];
	answer_t   expected_answers[$];
	int        error_count = 0;
	bit        stimulus_done = 0;
	longint    cycle_count = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	int        hold_off = 0;
	int        transfers_out = 0;

	rational_arithmetic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// reduced fraction, zero normalized to +0/1
	function automatic void lowest_terms(ref answer_t a, input logic neg,
			input logic [63:0] num, input logic [63:0] den);
		logic [63:0] g;
		if (num == 0 || den == 0) begin
			a.res_neg = 0;
			a.res_num = 0;
			a.res_den = 1;
		end else begin
			g = euclid_gcd(num, den);
			a.res_neg = neg;
			a.res_num = 63'(num / g);
			a.res_den = 63'(den / g);
		end
	endfunction

	function automatic answer_t rational_result(operands_t op);
		answer_t a;
		logic [63:0] l, r, mag, q, m;
		logic sa, sc, sr, neg, exact;
		logic [63:0] av, bv, cv, dv;
		av = 64'(op.lhs_num);
		bv = 64'(op.lhs_den);
		cv = 64'(op.rhs_num);
		dv = 64'(op.rhs_den);
		sa = op.lhs_neg && av != 0;
		sc = op.rhs_neg && cv != 0;
		a = '0;
		a.res_den = 1;
		if (bv == 0 || (op.cmd <= rau_pkg::CMD_CMP && dv == 0)) begin
			a.status = rau_pkg::ST_ZDEN;
			return a;
		end
		a.status = rau_pkg::ST_OK;
		case (op.cmd)
			rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
				l = av * dv;
				r = cv * bv;
				sr = (op.cmd == rau_pkg::CMD_SUB) ? (!sc && cv != 0) : sc;
				if (sa == sr) begin
					mag = l + r;
					neg = sa;
				end else if (l >= r) begin
					mag = l - r;
					neg = sa;
				end else begin
					mag = r - l;
					neg = sr;
				end
				lowest_terms(a, neg && mag != 0, mag, bv * dv);
			end
			rau_pkg::CMD_MUL: lowest_terms(a, sa != sc, av * cv, bv * dv);
			rau_pkg::CMD_DIV: begin
				if (cv == 0)
					a.status = rau_pkg::ST_DIVZ;
				else
					lowest_terms(a, sa != sc, av * dv, bv * cv);
			end
			rau_pkg::CMD_CMP: begin
				l = av * dv;
				r = cv * bv;
				if (sa != sc) begin
					a.less_than = sa;
					a.equal = 0;
				end else begin
					a.less_than = sa ? (l > r) : (l < r);
					a.equal = (l == r);
				end
			end
			rau_pkg::CMD_FLOOR, rau_pkg::CMD_CEIL: begin
				q = av / bv;
				exact = (av % bv) == 0;
				if (sa) begin
					m = (op.cmd == rau_pkg::CMD_FLOOR && !exact) ? q + 1 : q;
					a.int_result = 32'(64'd0 - m);
				end else begin
					a.int_result = 32'((op.cmd == rau_pkg::CMD_CEIL && !exact) ? q + 1 : q);
				end
			end
			default: lowest_terms(a, sa, av, bv);
		endcase
		return a;
	endfunction

	// magnitudes spread over extremes, small values and full width
	function automatic logic [30:0] pick_mag();
		case ($urandom_range(0, 7))
			0: return 31'($urandom_range(0, 3));
			1: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
			2, 3: return 31'($urandom_range(1, 60));
			4: return 31'($urandom_range(1, 5000));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic push_item(logic [2:0] c, logic ln, logic [30:0] an, logic [30:0] ad,
			logic rn, logic [30:0] bn, logic [30:0] bd);
		operands_t op;
		op.cmd = c;
		op.lhs_neg = ln;
		op.lhs_num = an;
		op.lhs_den = ad;
		op.rhs_neg = rn;
		op.rhs_num = bn;
		op.rhs_den = bd;
		pending_ops.push_back(op);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// stimulus: directed corners then random items
	initial begin
		logic [30:0] an, ad, bn, bd;
		logic [30:0] full;
		full = 31'h7FFFFFFF;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		for (int c = 0; c < 8; c++)
			push_item(3'(c), 1, 7, 3, 0, 5, 2);
		push_item(rau_pkg::CMD_ADD, 0, full, full, 1, full, 1);
		push_item(rau_pkg::CMD_MUL, 1, full, 1, 1, full, 1);
		push_item(rau_pkg::CMD_DIV, 0, 1, full, 0, full, 1);
		push_item(rau_pkg::CMD_DIV, 1, 5, 3, 1, 0, 7);      // division by zero
		push_item(rau_pkg::CMD_ADD, 0, 5, 0, 0, 5, 3);      // zero left denominator
		push_item(rau_pkg::CMD_CMP, 0, 5, 3, 0, 5, 0);      // zero right denominator
		push_item(rau_pkg::CMD_FLOOR, 0, 5, 3, 0, 5, 0);    // right den ignored
		push_item(rau_pkg::CMD_RED, 1, 0, 9, 0, 0, 0);      // negative zero
		push_item(rau_pkg::CMD_SUB, 1, 3, 4, 1, 3, 4);      // zero result
		push_item(rau_pkg::CMD_MUL, 1, 0, 5, 0, 3, 4);      // would be negative zero
		push_item(rau_pkg::CMD_CMP, 1, 0, 5, 0, 0, 9);      // -0 == 0
		push_item(rau_pkg::CMD_CMP, 1, 2, 4, 1, 1, 2);      // equal unreduced
		push_item(rau_pkg::CMD_FLOOR, 1, 7, 2, 0, 1, 1);
		push_item(rau_pkg::CMD_CEIL, 1, 7, 2, 0, 1, 1);
		push_item(rau_pkg::CMD_FLOOR, 1, full, 1, 0, 1, 1);
		push_item(rau_pkg::CMD_CEIL, 0, full, 1, 0, 1, 1);
		push_item(rau_pkg::CMD_RED, 0, 6, 4, 0, 0, 0);

		for (int i = 0; i < N_RANDOM; i++) begin
			an = pick_mag();
			ad = pick_mag();
			bn = pick_mag();
			bd = pick_mag();
			// keep denominators mostly nonzero so arithmetic paths dominate
			if (ad == 0 && $urandom_range(0, 3) != 0) ad = 1;
			if (bd == 0 && $urandom_range(0, 3) != 0) bd = 1;
			push_item(3'($urandom_range(0, 7)), 1'($urandom), an, ad,
				1'($urandom), bn, bd);
		end
		stimulus_done = 1;
	end

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_answers.push_back(rational_result(operands_t'(s_axis_tdata[128:0])));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 0;
				end else if (pending_ops.size() > 0) begin
					s_axis_tdata <= 136'(pending_ops.pop_front());
					s_axis_tvalid <= 1;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	// receiver stall pattern, with one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			hold_off <= 0;
		end else if (transfers_out == 40 && hold_off == 0) begin
			hold_off <= 2000;
			m_axis_tready <= 0;
		end else if (hold_off > 1) begin
			hold_off <= hold_off - 1;
		end else begin
			if (hold_off == 1)
				hold_off <= -1;
			if ((cycle_count / 3000) % 2 == 0)
				m_axis_tready <= 1;
			else
				m_axis_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	// monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			transfers_out <= transfers_out + 1;
			got = answer_t'(m_axis_tdata[162:0]);
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				error_count++;
			end else begin
				want = expected_answers.pop_front();
				if (got.res_neg !== want.res_neg) begin
					$display("%0t: res_neg exp %0d got %0d", $time, want.res_neg, got.res_neg);
					error_count++;
				end
				if (got.res_num !== want.res_num) begin
					$display("%0t: res_num exp %0d got %0d", $time, want.res_num, got.res_num);
					error_count++;
				end
				if (got.res_den !== want.res_den) begin
					$display("%0t: res_den exp %0d got %0d", $time, want.res_den, got.res_den);
					error_count++;
				end
				if (got.int_result !== want.int_result) begin
					$display("%0t: int_result exp %0d got %0d", $time,
						$signed(want.int_result), $signed(got.int_result));
					error_count++;
				end
				if (got.less_than !== want.less_than) begin
					$display("%0t: less_than exp %0d got %0d", $time,
						want.less_than, got.less_than);
					error_count++;
				end
				if (got.equal !== want.equal) begin
					$display("%0t: equal exp %0d got %0d", $time, want.equal, got.equal);
					error_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					error_count++;
				end
			end
		end
	end

	// end of run and watchdog
	initial begin
		wait (stimulus_done);
		while (pending_ops.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (error_count == 0 && expected_answers.size() == 0)
			$display("** rational_arithmetic_unit: PASSED **");
		else
			$display("** rational_arithmetic_unit: FAILED **");
		$finish;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** rational_arithmetic_unit: FAILED **");
			$finish;
		end
	end

endmodule
